// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue: the operation and
// status codes, one stored entry and the per-cycle command to the cell row.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int ValueWidth  = 32;
	localparam int PrioWidth   = 16;
	localparam int CountOutW   = 5;

	// Operation codes carried by one input transaction
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	// Status codes reported with every result
	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_DELETED   = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	// One queue entry
	typedef struct packed {
		logic signed [ValueWidth-1:0] value;
		logic signed [PrioWidth-1:0]  prio;
	} entry_t;

	// Command broadcast to every cell in the row
	typedef struct packed {
		logic   ins_en;
		logic   del_en;
		entry_t item;
	} cmd_t;

endpackage

// ===== rtl/core/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept in order in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// The queue takes one transaction per clock and returns exactly one result
// for each, in the cycle after acceptance, from an output register; a new
// transaction is taken while that result waits as long as rsp_ready frees the
// register in the same cycle. Every cell compares the broadcast priority with
// its own entry in parallel and shifts in one step, so the sustained rate is
// one item per cycle at any QUEUE_DEPTH; the critical path is one 16-bit
// compare plus the neighbor select. Entries of equal priority leave in arrival
// order. entry_count shows the low five bits of the count.
module sorted_priority_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        operation,
	input  logic signed [31:0] item_value,
	input  logic signed [15:0] item_prio,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic signed [31:0] out_value,
	output logic [1:0]  status,
	output logic        is_empty,
	output logic [4:0]  entry_count
);
	import spq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0] count_q;
	logic          rsp_valid_q;
	logic signed [ValueWidth-1:0] out_value_q;
	status_t       status_q;
	logic          is_empty_q;
	logic [CW-1:0] rsp_count_q;

	logic    accept;
	logic    is_full;
	logic    is_zero;
	cmd_t    cmd;
	status_t next_status;
	logic [CW-1:0] next_count;
	logic [CW+CountOutW-1:0] count_wide;

	logic   [QUEUE_DEPTH-1:0] keep;
	entry_t entries [QUEUE_DEPTH];

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign is_full   = (count_q == CW'(QUEUE_DEPTH));
	assign is_zero   = (count_q == '0);

	// Decode the transaction into a row command and its status
	always_comb begin
		cmd.item.value = item_value;
		cmd.item.prio  = item_prio;
		cmd.ins_en     = 1'b0;
		cmd.del_en     = 1'b0;
		next_count     = count_q;
		if (op_t'(operation) == OP_INSERT) begin
			if (is_full) begin
				next_status = ST_OVERFLOW;
			end else begin
				next_status = ST_INSERTED;
				cmd.ins_en  = accept;
				next_count  = count_q + CW'(1);
			end
		end else begin
			if (is_zero) begin
				next_status = ST_UNDERFLOW;
			end else begin
				next_status = ST_DELETED;
				cmd.del_en  = accept;
				next_count  = count_q - CW'(1);
			end
		end
	end

	// Build the cell row
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   occupied;
		logic   left_keep;
		entry_t left_entry;
		entry_t right_entry;

		assign occupied = (count_q > CW'(i));

		if (i == 0) begin : g_first
			assign left_keep  = 1'b1;
			assign left_entry = cmd.item;
		end else begin : g_mid
			assign left_keep  = keep[i-1];
			assign left_entry = entries[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_entry = '0;
		end else begin : g_inner
			assign right_entry = entries[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occupied    (occupied),
			.left_keep   (left_keep),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.keep        (keep[i]),
			.entry       (entries[i])
		);
	end

	// Track the occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= next_count;
		end
	end

	// Hold the result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_value_q <= (next_status == ST_DELETED) ? entries[0].value : '0;
			status_q    <= next_status;
			is_empty_q  <= (next_count == '0);
			rsp_count_q <= next_count;
		end
	end

	assign count_wide  = {{CountOutW{1'b0}}, rsp_count_q};
	assign rsp_valid   = rsp_valid_q;
	assign out_value   = out_value_q;
	assign status      = status_q;
	assign is_empty    = is_empty_q;
	assign entry_count = count_wide[CountOutW-1:0];

	// Count never passes the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
	else $error("occupancy count exceeds queue depth");

	// A successful delete lowers the count by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op_t'(operation) == OP_DELETE && !is_zero)
		|=> (count_q == $past(count_q) - CW'(1)))
	else $error("delete did not lower the count");

	// A rejected insert leaves the count unchanged and reports overflow
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op_t'(operation) == OP_INSERT && is_full)
		|=> (count_q == $past(count_q) && status_q == ST_OVERFLOW))
	else $error("overflow insert changed the queue");

	// Only a delete returns a nonzero value
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q != ST_DELETED) |-> (out_value_q == '0))
	else $error("nonzero value without a delete");

endmodule

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row. Compares its entry against a new item, then
// holds, takes the new item, shifts in from the left or from the right.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic           clk,
	input  spq_pkg::cmd_t  cmd,
	input  logic           occupied,
	input  logic           left_keep,
	input  spq_pkg::entry_t left_entry,
	input  spq_pkg::entry_t right_entry,
	output logic           keep,
	output spq_pkg::entry_t entry
);
	import spq_pkg::*;

	entry_t entry_q;

	// Hold this entry on insert when it stays ahead of the new item
	assign keep  = occupied && (entry_q.prio <= cmd.item.prio);
	assign entry = entry_q;

	// Insert: take new item at the boundary, else shift right; delete: shift left
	always_ff @(posedge clk) begin
		if (cmd.ins_en && !keep) begin
			if (left_keep) begin
				entry_q <= cmd.item;
			end else begin
				entry_q <= left_entry;
			end
		end else if (cmd.del_en) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== dv/sorted_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Checks the sorted priority queue against an ordered list kept in the bench.
// ----------------------------------------------------------------------------
// A table of directed transactions covers the empty and full cases, the field
// extremes and equal priorities. Random traffic follows in insert-heavy,
// delete-heavy and mixed phases so the queue fills and drains many times.
// The sender works in bursts with gaps and the receiver stalls on a pattern of
// its own. Every response is compared field by field with the oldest expected
// result.
module sorted_priority_queue_tb;
	import spq_pkg::*;

	localparam int ClkPeriod   = 10;
	localparam int QueueDepth  = 16;
	localparam int TotalItems  = 1150;
	localparam int IdleLimit   = 2000;
	localparam int DrainCycles = 8;
	localparam int DirRows     = 21;

	// One result of the queue
	typedef struct packed {
		logic signed [31:0] value;
		status_t            st;
		logic               empty;
		logic [4:0]         count;
	} spq_result_t;

	// One row of directed stimulus; known marks a result typed in by hand
	typedef struct {
		op_t                op;
		logic signed [31:0] value;
		logic signed [15:0] prio;
		bit                 known;
		spq_result_t        res;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	op_t                operation = OP_INSERT;
	logic signed [31:0] item_value = '0;
	logic signed [15:0] item_prio = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	logic signed [31:0] out_value;
	logic [1:0]         status;
	logic               is_empty;
	logic [4:0]         entry_count;

	// Bench copy of the queue, front at index 0
	entry_t      held_entries[$];
	// Results still owed by the block, oldest first
	spq_result_t expected_results[$];
	// Hand-typed results for transactions not yet accepted, in send order
	bit          known_flags[$];
	spq_result_t known_results[$];

	int error_count = 0;
	int idle_cycles = 0;
	int items_sent  = 0;
	int burst_left  = 0;

	localparam spq_result_t NoRes = '{32'sd0, ST_INSERTED, 1'b0, 5'd0};

	stim_row_t dir_rows [DirRows] = '{
		'{OP_DELETE, 32'sd0,          16'sd0,      1'b1, '{32'sd0, ST_UNDERFLOW, 1'b1, 5'd0}},
		'{OP_INSERT, 32'sh7FFFFFFF,   16'sh7FFF,   1'b1, '{32'sd0, ST_INSERTED, 1'b0, 5'd1}},
		'{OP_INSERT, 32'sh80000000,   16'sh8000,   1'b1, '{32'sd0, ST_INSERTED, 1'b0, 5'd2}},
		'{OP_INSERT, 32'sd11,         16'sd5,      1'b0, NoRes},
		'{OP_INSERT, 32'sd22,         16'sd5,      1'b0, NoRes},
		'{OP_INSERT, 32'sd0,          16'sd0,      1'b0, NoRes},
		'{OP_DELETE, 32'sh12345678,   16'sh7FFF,   1'b1,
			'{32'sh80000000, ST_DELETED, 1'b0, 5'd4}},
		'{OP_INSERT, 32'sd33,         16'sd5,      1'b0, NoRes},
		'{OP_INSERT, -32'sd5,         -16'sd1,     1'b0, NoRes},
		'{OP_INSERT, 32'sd1,          16'sh7FFF,   1'b0, NoRes},
		'{OP_INSERT, 32'sd2,          16'sh8000,   1'b0, NoRes},
		'{OP_INSERT, 32'sd44,         16'sd5,      1'b0, NoRes},
		'{OP_INSERT, 32'sd3,          16'sd0,      1'b0, NoRes},
		'{OP_INSERT, 32'sd4,          16'sd1,      1'b0, NoRes},
		'{OP_INSERT, 32'sd6,          -16'sd2,     1'b0, NoRes},
		'{OP_INSERT, 32'sd7,          16'sd100,    1'b0, NoRes},
		'{OP_INSERT, 32'sd8,          16'sd5,      1'b0, NoRes},
		'{OP_INSERT, 32'sd9,          -16'sd32767, 1'b0, NoRes},
		'{OP_INSERT, 32'sd10,         16'sd32766,  1'b0, NoRes},
		'{OP_INSERT, -32'sd1,         16'sd0,      1'b1, '{32'sd0, ST_OVERFLOW, 1'b0, 5'd16}},
		'{OP_DELETE, 32'sd0,          16'sd0,      1'b0, NoRes}
	};

	sorted_priority_queue #(
		.QUEUE_DEPTH(QueueDepth)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.operation    (operation),
		.item_value   (item_value),
		.item_prio    (item_prio),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.out_value    (out_value),
		.status       (status),
		.is_empty     (is_empty),
		.entry_count  (entry_count)
	);

	always #(ClkPeriod / 2) clk = ~clk;

	// Apply one transaction to the bench queue and return its result
	function automatic spq_result_t apply_queue_op(op_t op, logic signed [31:0] val,
			logic signed [15:0] pr);
		spq_result_t res;
		entry_t      fresh;
		int          pos;
		res = '0;
		if (op == OP_INSERT) begin
			if (held_entries.size() >= QueueDepth) begin
				res.st = ST_OVERFLOW;
			end else begin
				// place after every entry with an equal or smaller priority
				pos = 0;
				while (pos < held_entries.size() &&
						$signed(held_entries[pos].prio) <= $signed(pr))
					pos++;
				fresh.value = val;
				fresh.prio  = pr;
				held_entries.insert(pos, fresh);
				res.st = ST_INSERTED;
			end
		end else begin
			if (held_entries.size() == 0) begin
				res.st = ST_UNDERFLOW;
			end else begin
				res.value = held_entries[0].value;
				held_entries.pop_front();
				res.st = ST_DELETED;
			end
		end
		res.empty = (held_entries.size() == 0);
		res.count = 5'(held_entries.size());
		return res;
	endfunction

	// Compare one response with its expected result, field by field
	function automatic void compare_result(spq_result_t exp_res, spq_result_t act_res);
		if (act_res.value !== exp_res.value) begin
			$display("%0t: out_value mismatch: expected %0d, actual %0d",
				$time, exp_res.value, act_res.value);
			error_count++;
		end
		if (act_res.st !== exp_res.st) begin
			$display("%0t: status mismatch: expected %0d, actual %0d",
				$time, exp_res.st, act_res.st);
			error_count++;
		end
		if (act_res.empty !== exp_res.empty) begin
			$display("%0t: is_empty mismatch: expected %0d, actual %0d",
				$time, exp_res.empty, act_res.empty);
			error_count++;
		end
		if (act_res.count !== exp_res.count) begin
			$display("%0t: entry_count mismatch: expected %0d, actual %0d",
				$time, exp_res.count, act_res.count);
			error_count++;
		end
	endfunction

	// Predict on each accepted request, then check each accepted response
	always @(posedge clk) begin
		spq_result_t predicted;
		spq_result_t observed;
		if (arst_n && req_valid && req_ready) begin
			predicted = apply_queue_op(operation, item_value, item_prio);
			if (known_flags.size() == 0) begin
				$display("%0t: request accepted with nothing sent", $time);
				error_count++;
			end else begin
				if (known_flags.pop_front())
					predicted = known_results.pop_front();
				else
					void'(known_results.pop_front());
			end
			expected_results.push_back(predicted);
		end
		if (arst_n && rsp_valid && rsp_ready) begin
			observed = '{out_value, status_t'(status), is_empty, entry_count};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected response: expected none, actual %0d/%0d/%0d/%0d",
					$time, observed.value, observed.st, observed.empty, observed.count);
				error_count++;
			end else begin
				compare_result(expected_results.pop_front(), observed);
			end
		end
	end

	// Receiver: stall in runs whose length depends on a slowly changing mode
	int stall_left = 0;
	int stall_mode = 0;
	int mode_timer = 0;
	always @(posedge clk) begin
		if (mode_timer == 0) begin
			mode_timer <= $urandom_range(50, 250);
			stall_mode <= $urandom_range(0, 2);
		end else begin
			mode_timer <= mode_timer - 1;
		end
		if (stall_left != 0) begin
			rsp_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			rsp_ready <= 1'b1;
			if (stall_mode == 1 && $urandom_range(0, 2) == 0)
				stall_left <= $urandom_range(1, 2);
			else if (stall_mode == 2 && $urandom_range(0, 5) == 0)
				stall_left <= $urandom_range(3, 12);
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("%0t: watchdog expired", $time);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Send one transaction and hold it until accepted, then maybe pause
	task automatic send_item(op_t op, logic signed [31:0] val, logic signed [15:0] pr,
			bit known, spq_result_t res);
		int gap;
		known_flags.push_back(known);
		known_results.push_back(res);
		req_valid  <= 1'b1;
		operation  <= op;
		item_value <= val;
		item_prio  <= pr;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drop valid and hold until every owed result has arrived
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		do @(posedge clk);
		while (expected_results.size() != 0 || known_flags.size() != 0);
	endtask

	// Stimulus: directed table, then random phases
	initial begin
		int                 ins_pct;
		int                 pick;
		op_t                op;
		logic signed [31:0] val;
		logic signed [15:0] pr;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].prio,
				dir_rows[i].known, dir_rows[i].res);
		wait_for_drain();

		ins_pct = 50;
		while (items_sent < TotalItems) begin
			// switch between filling, draining and mixed traffic
			if (items_sent % 40 == 0) begin
				pick = $urandom_range(0, 2);
				ins_pct = (pick == 0) ? 85 : (pick == 1) ? 15 : 50;
			end
			if (items_sent == TotalItems / 2)
				wait_for_drain();
			op  = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DELETE;
			val = $urandom;
			pick = $urandom_range(0, 9);
			if (pick < 6)
				pr = 16'($signed($urandom_range(0, 6)) - 3);
			else if (pick < 9)
				pr = 16'($urandom_range(0, 65535));
			else
				pr = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			send_item(op, val, pr, 1'b0, NoRes);
		end

		wait_for_drain();
		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
dv/sorted_priority_queue_tb.sv
